FILE: hdl/crc32e_pkg.sv
`timescale 1ns / 1ps

package crc32e_pkg;

  // Reflected CRC-32 polynomial (zlib / Ethernet).
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Default number of message bytes carried by one input word.
  localparam int BYTES_PER_ITEM_DEF = 8;

  // Width of the byte count field on the input port.
  localparam int COUNT_W = 4;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified word as it travels from the front to the back.
  // part holds the CRC contribution of the data bytes alone, taken from a
  // zero remainder; count is already saturated to the word width.
  typedef struct packed {
    logic [31:0]        part;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               first;
  } item_t;

  // Folds one byte into a reflected CRC remainder, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] rem, input logic [7:0] b);
    logic [31:0] r;
    r = rem ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: hdl/crc32e_front.sv
`timescale 1ns / 1ps

module crc32e_front import crc32e_pkg::*; #(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [8*BYTES_PER_ITEM-1:0] data_bytes,
  input  logic [COUNT_W-1:0]          byte_count,
  input  logic                        last_item,
  output item_t                       item
);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(BYTES_PER_ITEM);

  // High while a message has been opened by an earlier word and not closed.
  logic                in_message;
  logic [COUNT_W-1:0]  count_sat;
  logic [31:0]         part;

  always_comb begin
    count_sat = (byte_count > MAX_COUNT) ? MAX_COUNT : byte_count;
  end

  // The CRC is linear, so the data bytes can be folded from a zero remainder
  // here, independent of the running remainder held in the back.
  always_comb begin
    part = 32'h0000_0000;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      if (COUNT_W'(i) < count_sat) begin
        part = crc_byte(part, data_bytes[8*i +: 8]);
      end
    end
  end

  always_comb begin
    item.part  = part;
    item.count = count_sat;
    item.last  = last_item;
    item.first = !in_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (accept) begin
      in_message <= !last_item;
    end
  end

endmodule

FILE: hdl/crc32e_queue.sv
`timescale 1ns / 1ps

module crc32e_queue import crc32e_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  rd_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full     = (fill == DEPTH_C);
  assign rd_valid = (fill != '0);
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/crc32e_back.sv
`timescale 1ns / 1ps

module crc32e_back import crc32e_pkg::*; #(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_value_we,
  input  logic [31:0] start_value,
  input  logic        item_valid,
  input  item_t       item,
  output logic        item_take,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] crc_value
);

  logic [31:0] start_reg;
  logic [31:0] remainder;
  logic [31:0] base;
  logic [31:0] advanced;
  logic [31:0] rem_next;
  logic        out_valid;
  logic        out_free;

  assign out_free  = !out_valid || pop;
  assign item_take = item_valid && (!item.last || out_free);
  assign empty     = !out_valid;

  // Run the old remainder through as many zero bytes as the word carries,
  // then merge the data contribution computed by the front.
  always_comb begin
    base = item.first ? ~start_reg : remainder;
    advanced = base;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      if (COUNT_W'(i) < item.count) begin
        advanced = crc_byte(advanced, 8'h00);
      end
    end
    rem_next = advanced ^ item.part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg <= 32'h0000_0000;
    end else if (start_value_we) begin
      start_reg <= start_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= 32'h0000_0000;
      out_valid <= 1'b0;
    end else begin
      if (item_take) begin
        remainder <= rem_next;
      end
      if (item_take && item.last) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last) begin
      crc_value <= ~rem_next;
    end
  end

endmodule

FILE: hdl/crc32_eight_byte_engine_unit.sv
`timescale 1ns / 1ps
// An accepted word is written into the queue, then the back reads and folds it; a closing
// word's CRC is registered on the result ports. Throughput: the back folds one full word
// per cycle into the remainder while no closing word waits on an unpopped result.
// Reset: synchronous active-high rst clears the queue, the open-message flag, the remainder,
// the start value register and the result valid flag.

module crc32_eight_byte_engine_unit import crc32e_pkg::*; #(
  parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [8*BYTES_PER_ITEM-1:0] data_bytes,
  input  logic [COUNT_W-1:0]          byte_count,
  input  logic                        last_item,
  output logic                        empty,
  input  logic                        pop,
  output logic [31:0]                 crc_value,
  input  logic                        start_value_we,
  input  logic [31:0]                 start_value
);

  // The front classifies each accepted word: it saturates the byte count,
  // marks the word that opens a message, and folds the data bytes into a
  // zero remainder. Since the CRC is linear over GF(2), that data part can
  // be formed without knowing the running remainder.
  item_t front_item;
  logic  accept;

  assign accept = push && !full;

  crc32e_front #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_bytes(data_bytes),
    .byte_count(byte_count),
    .last_item (last_item),
    .item      (front_item)
  );

  // A short queue parts the front from the back, so a stalled result side
  // does not stop the input side until the queue fills.
  item_t q_item;
  logic  q_valid;
  logic  q_take;

  crc32e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_take),
    .rd_item (q_item),
    .rd_valid(q_valid)
  );

  // The back advances the running remainder through the word's zero bytes,
  // merges the data part, and on the last word of a message places the
  // inverted remainder in the result register. A result waiting to be
  // popped only holds back words that close a message.
  crc32e_back #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .start_value_we(start_value_we),
    .start_value   (start_value),
    .item_valid    (q_valid),
    .item          (q_item),
    .item_take     (q_take),
    .pop           (pop),
    .empty         (empty),
    .crc_value     (crc_value)
  );

endmodule
